@@ sv/nmea_rmc_pkg.sv @@
package nmea_rmc_pkg;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] HDR_LEN    = 3'd5;
  localparam logic [2:0] HDR_POS_M  = 3'd3;
  localparam logic [2:0] HDR_POS_C  = 3'd4;
  localparam logic [3:0] LAST_FIELD = 4'd9;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FIX_UNKNOWN = 2'd0,
    FIX_VALID   = 2'd1,
    FIX_VOID    = 2'd2
  } fix_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_HDR     = 4'b0010,
    ST_BODY    = 4'b0100,
    ST_DISCARD = 4'b1000
  } state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] field_index;
    logic [7:0] char_code;
    kind_e      kind;
    fix_e       fix_status;
  } out_beat_t;

endpackage

@@ sv/nmea_rmc_if.sv @@
interface nmea_rmc_in_if;
  import nmea_rmc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface nmea_rmc_out_if;
  import nmea_rmc_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] field_index;
  logic [7:0] char_code;
  kind_e      kind;
  fix_e       fix_status;

  modport source (output valid, output field_index, output char_code, output kind,
                  output fix_status, input ready);
  modport sink   (input valid, input field_index, input char_code, input kind,
                  input fix_status, output ready);
endinterface

@@ sv/nmea_rmc_in_stage.sv @@
module nmea_rmc_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  nmea_rmc_in_if.sink            in_i,
  input  logic                   item_take_i,
  output logic                   item_valid_o,
  output nmea_rmc_pkg::in_beat_t item_o
);
  import nmea_rmc_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     load;

  assign in_i.ready = !valid_q || item_take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= '{rx_byte: in_i.rx_byte, chunk_last: in_i.chunk_last};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = beat_q;

endmodule

@@ sv/nmea_rmc_parser.sv @@
module nmea_rmc_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  nmea_rmc_pkg::in_beat_t  item_i,
  output logic                    item_take_o,
  input  logic                    res_free_i,
  output logic                    res_load_o,
  output nmea_rmc_pkg::out_beat_t res_o
);
  import nmea_rmc_pkg::*;

  state_e     st_q, st_d;
  logic [2:0] pos_q, pos_d;
  logic       good_q, good_d;
  logic [3:0] field_q, field_d;
  fix_e       status_q, status_d;

  logic       res_valid;
  out_beat_t  res;
  logic       in_field;
  logic [7:0] b;

  assign b        = item_i.rx_byte;
  assign in_field = (field_q != 4'd0) && (field_q <= LAST_FIELD);

  always_comb begin
    st_d      = st_q;
    pos_d     = pos_q;
    good_d    = good_q;
    field_d   = field_q;
    status_d  = status_q;
    res_valid = 1'b0;
    res       = '{field_index: 4'd0, char_code: 8'd0, kind: KIND_CHAR, fix_status: status_q};

    priority if (st_q == ST_IDLE) begin
      if (b == CH_G && !item_i.chunk_last) begin
        st_d     = ST_HDR;
        pos_d    = 3'd1;
        good_d   = 1'b1;
        field_d  = 4'd0;
        status_d = FIX_UNKNOWN;
      end
    end else if (b == CH_NL || item_i.chunk_last) begin
      if (st_q == ST_BODY) begin
        res_valid = 1'b1;
        res.kind  = (b == CH_NL) ? KIND_END : KIND_ABORT;
      end
      st_d     = ST_IDLE;
      pos_d    = 3'd0;
      good_d   = 1'b0;
      field_d  = 4'd0;
      status_d = FIX_UNKNOWN;
    end else begin
      unique case (st_q)
        ST_HDR: begin
          if ((pos_q == HDR_POS_M && b != CH_M) || (pos_q == HDR_POS_C && b != CH_C)) begin
            good_d = 1'b0;
          end
          pos_d = pos_q + 3'd1;
          if (pos_d == HDR_LEN) begin
            st_d = good_d ? ST_BODY : ST_DISCARD;
          end
        end
        ST_BODY: begin
          if (b == CH_COMMA) begin
            if (field_q <= LAST_FIELD) begin
              field_d = field_q + 4'd1;
            end
            if (in_field) begin
              res_valid       = 1'b1;
              res.field_index = field_q;
              res.kind        = KIND_CLOSE;
            end
          end else if (in_field) begin
            if (field_q == 4'd2 && status_q == FIX_UNKNOWN) begin
              if (b == CH_A) begin
                status_d = FIX_VALID;
              end else if (b == CH_V) begin
                status_d = FIX_VOID;
              end
            end
            res_valid       = 1'b1;
            res.field_index = field_q;
            res.char_code   = b;
            res.fix_status  = status_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign item_take_o = item_valid_i && (!res_valid || res_free_i);
  assign res_load_o  = item_take_o && res_valid;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      pos_q    <= 3'd0;
      good_q   <= 1'b0;
      field_q  <= 4'd0;
      status_q <= FIX_UNKNOWN;
    end else if (item_take_o) begin
      st_q     <= st_d;
      pos_q    <= pos_d;
      good_q   <= good_d;
      field_q  <= field_d;
      status_q <= status_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_HDR |-> (pos_q >= 3'd1 && pos_q < HDR_LEN))
    else $error("header position out of range");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> (field_q == 4'd0 && status_q == FIX_UNKNOWN))
    else $error("idle with stale sentence state");

  a_field_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= LAST_FIELD + 4'd1)
    else $error("field counter beyond saturation");

  a_field_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o && (res.kind == KIND_CHAR || res.kind == KIND_CLOSE)
      |-> (st_q == ST_BODY && res.field_index >= 4'd1 && res.field_index <= LAST_FIELD))
    else $error("field result outside fields one to nine");

  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_BODY && status_q != FIX_UNKNOWN) |=> (st_q == ST_IDLE || $stable(status_q)))
    else $error("fix status changed after first set");
`endif

endmodule

@@ sv/nmea_rmc_out_stage.sv @@
module nmea_rmc_out_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    res_load_i,
  input  nmea_rmc_pkg::out_beat_t res_i,
  output logic                    res_free_o,
  nmea_rmc_out_if.source          out_o
);
  import nmea_rmc_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  assign res_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      beat_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.field_index = beat_q.field_index;
  assign out_o.char_code   = beat_q.char_code;
  assign out_o.kind        = beat_q.kind;
  assign out_o.fix_status  = beat_q.fix_status;

endmodule

@@ sv/nmea_rmc_field_splitter.sv @@
// Channel  Dir  Payload                                      Handshake
// in_i     in   rx_byte[7:0], chunk_last                     valid/ready
// out_o    out  field_index[3:0], char_code[7:0], kind[1:0], valid/ready
//               fix_status[1:0]
//
// One byte per cycle sustained while out_o is ready; a taken byte is held in the input
// register, passes the parser, and its result is held in the result register for out_o.
// Reset clears the stage valids and the sentence state; payload registers are not reset.
// A stalled result register holds back only bytes that produce a result; bytes that
// produce none keep flowing.
module nmea_rmc_field_splitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  nmea_rmc_in_if.sink   in_i,
  nmea_rmc_out_if.source out_o
);
  import nmea_rmc_pkg::*;

  logic      item_valid;
  in_beat_t  item;
  logic      item_take;
  logic      res_free;
  logic      res_load;
  out_beat_t res;

  nmea_rmc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_take_i  (item_take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  nmea_rmc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_free_i   (res_free),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  nmea_rmc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_load_i (res_load),
    .res_i      (res),
    .res_free_o (res_free),
    .out_o      (out_o)
  );

endmodule
